// File: sv/adp_pkg.sv
// Shared types and constants for the Art-Net DMX receive parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package adp_pkg;

    // Receive buffer capacity in payload bytes; bytes past it are ignored.
    localparam int RX_BUFFER_BYTES = 1024;
    localparam int POS_W           = $clog2(RX_BUFFER_BYTES + 1);

    // Byte offsets within the Art-Net payload.
    localparam int ID_LEN         = 8;
    localparam int OPCODE_LO_POS  = 8;
    localparam int OPCODE_HI_POS  = 9;
    localparam int MIN_HEADER_LEN = 10;
    localparam int SUBUNI_POS     = 14;
    localparam int NET_POS        = 15;
    localparam int LEN_HI_POS     = 16;
    localparam int LEN_LO_POS     = 17;
    localparam int DATA_OFFSET    = 18;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_OPCODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DMX_OPCODE  = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] POLL_OPCODE_RESET = 16'h2000;
    localparam logic [15:0] DMX_OPCODE_RESET  = 16'h5000;

    typedef enum logic [1:0] {
        EV_SLOT  = 2'd0,
        EV_EMPTY = 2'd1,
        EV_POLL  = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       packet_end;
    } in_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [14:0] universe;
        logic [9:0]  slot_index;
        logic [7:0]  slot_value;
        logic        last_slot;
    } out_t;

    // Expected "Art-Net\0" identifier, one byte per header position.
    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'h41;
            3'd1: b = 8'h72;
            3'd2: b = 8'h74;
            3'd3: b = 8'h2D;
            3'd4: b = 8'h4E;
            3'd5: b = 8'h65;
            3'd6: b = 8'h74;
            3'd7: b = 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/artnet_dmx_packet_parser_core.sv
// An accepted byte's result is registered in the output buffer before it appears on out_data.
// Throughput: one payload byte per cycle while in_stall is low; field capture and event decision take one pass.
// A two-entry output buffer keeps input flowing while one result waits; in_stall rises
// only when both entries hold results.
// Reset: enable 0, opcodes 0x2000 / 0x5000, packet state cleared, output buffer empty.
// Top level of the Art-Net DMX parser; depends on adp_pkg, adp_parser, adp_obuf.
`timescale 1ns / 1ps

module artnet_dmx_packet_parser_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  adp_pkg::in_t                        in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output adp_pkg::out_t                       out_data,
    input  logic                                cfg_we,
    input  logic [adp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [adp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import adp_pkg::*;

    logic        enable_reg;
    logic [15:0] poll_opcode_reg;
    logic [15:0] dmx_opcode_reg;
    logic        accept;
    logic        push;
    out_t        push_data;
    logic        full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            poll_opcode_reg <= POLL_OPCODE_RESET;
            dmx_opcode_reg  <= DMX_OPCODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:      enable_reg      <= cfg_data[0];
                REG_POLL_OPCODE: poll_opcode_reg <= cfg_data;
                REG_DMX_OPCODE:  dmx_opcode_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    adp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_data     (in_data),
        .enable      (enable_reg),
        .poll_opcode (poll_opcode_reg),
        .dmx_opcode  (dmx_opcode_reg),
        .push        (push),
        .push_data   (push_data)
    );

    adp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: sv/adp_parser.sv
// Per-byte Art-Net field capture and event decision.
// Depends on adp_pkg; feeds adp_obuf from the top level.
`timescale 1ns / 1ps

module adp_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  adp_pkg::in_t  in_data,
    input  logic          enable,
    input  logic [15:0]   poll_opcode,
    input  logic [15:0]   dmx_opcode,
    output logic          push,
    output adp_pkg::out_t push_data
);
    import adp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             header_good_reg, header_good_next;
    logic [15:0]      opcode_reg, opcode_next;
    logic [14:0]      universe_reg, universe_next;
    logic [15:0]      length_reg, length_next;

    logic             in_buffer;
    logic             is_poll;
    logic             is_dmx;
    logic [15:0]      idx_wide;
    logic             slot_last;
    logic [7:0]       b;

    assign b         = in_data.byte_value;
    assign in_buffer = pos_reg < POS_W'(RX_BUFFER_BYTES);

    // Field capture by position within the packet.
    always_comb
    begin
        header_good_next = header_good_reg;
        opcode_next      = opcode_reg;
        universe_next    = universe_reg;
        length_next      = length_reg;
        if (pos_reg < POS_W'(ID_LEN))
        begin
            if (b != id_byte(pos_reg[2:0]))
                header_good_next = 1'b0;
        end
        else if (pos_reg == POS_W'(OPCODE_LO_POS))
            opcode_next = {8'h00, b};
        else if (pos_reg == POS_W'(OPCODE_HI_POS))
            opcode_next = {b, opcode_reg[7:0]};
        else if (pos_reg == POS_W'(SUBUNI_POS))
            universe_next = {universe_reg[14:8], b};
        else if (pos_reg == POS_W'(NET_POS))
            universe_next = {b[6:0], universe_reg[7:0]};
        else if (pos_reg == POS_W'(LEN_HI_POS))
            length_next = {b, 8'h00};
        else if (pos_reg == POS_W'(LEN_LO_POS))
            length_next = {length_reg[15:8], b};
    end

    assign is_poll  = header_good_next && (opcode_next == poll_opcode);
    assign is_dmx   = header_good_next && !is_poll && (opcode_next == dmx_opcode);
    assign idx_wide = 16'(pos_reg) - 16'(DATA_OFFSET);
    assign slot_last = (idx_wide + 16'd1 == length_next) || in_data.packet_end ||
                       (pos_reg == POS_W'(RX_BUFFER_BYTES - 1));

    // Event decision.
    always_comb
    begin
        push                 = 1'b0;
        push_data.event_kind = EV_SLOT;
        push_data.universe   = 15'd0;
        push_data.slot_index = 10'd0;
        push_data.slot_value = 8'd0;
        push_data.last_slot  = 1'b0;
        if (accept && enable && in_buffer)
        begin
            if (pos_reg == POS_W'(MIN_HEADER_LEN - 1) && is_poll)
            begin
                push                 = 1'b1;
                push_data.event_kind = EV_POLL;
            end
            else if (pos_reg == POS_W'(DATA_OFFSET - 1) && is_dmx)
            begin
                if (length_next == 16'd0 || in_data.packet_end)
                begin
                    push                 = 1'b1;
                    push_data.event_kind = EV_EMPTY;
                    push_data.universe   = universe_next;
                end
            end
            else if (pos_reg >= POS_W'(DATA_OFFSET) && is_dmx)
            begin
                if (idx_wide < length_next)
                begin
                    push                 = 1'b1;
                    push_data.event_kind = EV_SLOT;
                    push_data.universe   = universe_next;
                    push_data.slot_index = idx_wide[9:0];
                    push_data.slot_value = b;
                    push_data.last_slot  = slot_last;
                end
            end
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (in_buffer)
            pos_next = pos_reg + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            header_good_reg <= 1'b1;
            opcode_reg      <= 16'd0;
            universe_reg    <= 15'd0;
            length_reg      <= 16'd0;
        end
        else if (accept && enable)
        begin
            if (in_data.packet_end)
            begin
                // drop all packet state after the closing byte
                pos_reg         <= '0;
                header_good_reg <= 1'b1;
                opcode_reg      <= 16'd0;
                universe_reg    <= 15'd0;
                length_reg      <= 16'd0;
            end
            else if (in_buffer)
            begin
                pos_reg         <= pos_next;
                header_good_reg <= header_good_next;
                opcode_reg      <= opcode_next;
                universe_reg    <= universe_next;
                length_reg      <= length_next;
            end
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(RX_BUFFER_BYTES))
        else $error("byte position past buffer capacity");

    a_poll_clean: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_data.event_kind == EV_POLL |->
            push_data.universe == 15'd0 && !push_data.last_slot)
        else $error("poll event carries slot fields");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && enable && in_data.packet_end |=> pos_reg == '0 && header_good_reg)
        else $error("packet state not cleared after packet end");

endmodule

// File: sv/adp_obuf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on adp_pkg for the result type.
`timescale 1ns / 1ps

module adp_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  adp_pkg::out_t push_data,
    output logic          full,
    output logic          out_valid,
    input  logic          out_stall,
    output adp_pkg::out_t out_data
);
    import adp_pkg::*;

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;
    logic skid_valid_reg, skid_valid_next;
    out_t skid_data_reg, skid_data_next;
    logic pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                // advance the held transaction, catch the new one behind it
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with output register empty");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && skid_valid_reg && !pop))
        else $error("result pushed into a full buffer");

    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> out_valid_reg)
        else $error("skid entry lost on pop");

endmodule
